// ===== sv/ext4_inode_locator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// ext4 inode locator assertion macros
// shared property forms for the locator checks
// ---------------------------------------------------------------------------
`ifndef EXT4_INODE_LOCATOR_UNIT_MACROS_SVH
`define EXT4_INODE_LOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define E4IL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("e4il same-cycle check failed");

// next-cycle implication
`define E4IL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("e4il next-cycle check failed");

`endif

// ===== sv/e4il_pkg.sv =====
// ---------------------------------------------------------------------------
// e4il_pkg
// types and constants of the ext4 inode locator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package e4il_pkg;

  localparam int unsigned MinBlockBytes = 1024;
  localparam int unsigned MinBlockLog   = 10;

  localparam logic [2:0] RegBlockSizeLog  = 3'd0;
  localparam logic [2:0] RegInodesPerGrp  = 3'd1;
  localparam logic [2:0] RegInodeSize     = 3'd2;
  localparam logic [2:0] RegBlocksPerGrp  = 3'd3;
  localparam logic [2:0] RegLayoutFlags   = 3'd4;
  localparam logic [2:0] RegBackupGroupA  = 3'd5;
  localparam logic [2:0] RegBackupGroupB  = 3'd6;
  localparam logic [2:0] RegDescSize      = 3'd7;

  localparam logic [1:0] SparseV1 = 2'd1;
  localparam logic [1:0] SparseV2 = 2'd2;

  typedef struct packed {
    logic [31:0] inode_number;
    logic [47:0] table_start_block;
  } in_item_t;

  typedef struct packed {
    logic [62:0] descriptor_address;
    logic [62:0] inode_address;
    logic [31:0] group_number;
    logic        bad_inode;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TBL,
    ST_BLK,
    ST_GRP,
    ST_GIX,
    ST_PRT,
    ST_BKP,
    ST_MUL,
    ST_FIN
  } seq_state_e;

endpackage

// ===== sv/e4il_div.sv =====
// ---------------------------------------------------------------------------
// e4il_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module e4il_div
  import e4il_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [17:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [17:0] rem_o
);

  logic        run_q, run_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [17:0] dvs_q, dvs_d;
  logic [18:0] trial;

  assign trial = {rem_q, quo_q[31]};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 6'd32;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (cnt_q == 6'd0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 6'd1;
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = 18'(trial - {1'b0, dvs_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial[17:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = run_q && (cnt_q == 6'd0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/e4il_pwr_chk.sv =====
// ---------------------------------------------------------------------------
// e4il_pwr_chk
// tests a group number for a power of 3, 5 or 7 by stepping a product
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module e4il_pwr_chk
  import e4il_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] group_i,
  output logic        done_o,
  output logic        hit_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic        hit_q, hit_d;
  logic [1:0]  sel_q, sel_d;
  logic [34:0] p_q, p_d;
  logic [31:0] g_q, g_d;
  logic [34:0] p_next;

  always_comb begin
    case (sel_q)
      2'd0:    p_next = (p_q << 1) + p_q;
      2'd1:    p_next = (p_q << 2) + p_q;
      default: p_next = (p_q << 3) - p_q;
    endcase
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    hit_d  = hit_q;
    sel_d  = sel_q;
    p_d    = p_q;
    g_d    = g_q;
    if (start_i) begin
      run_d = 1'b1;
      hit_d = 1'b0;
      sel_d = 2'd0;
      p_d   = 35'd1;
      g_d   = group_i;
    end else if (run_q) begin
      if (p_q == 35'(g_q)) begin
        hit_d  = 1'b1;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (p_q > 35'(g_q)) begin
        if (sel_q == 2'd2) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          sel_d = sel_q + 2'd1;
          p_d   = 35'd1;
        end
      end else begin
        p_d = p_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      sel_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      hit_q  <= hit_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

endmodule

// ===== sv/ext4_inode_locator_unit.sv =====
// ---------------------------------------------------------------------------
// ext4_inode_locator_unit
// locates an inode's group, group descriptor and inode record on the volume
//
//   channel   direction  payload
//   in        input      in_item_t  (inode number, inode table start block)
//   out       output     out_item_t (descriptor and inode address, group, flag)
//   cfg       input      index 3 bits, data 32 bits, write only
//
// each item runs from acceptance through five divider passes, a power
// test and a shift-add multiply, after which the result is loaded
// an inode number of zero skips all of that and goes straight to the load
// the input stays stalled from acceptance until the result is registered
// the next item is taken while a finished result waits for the output side
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ext4_inode_locator_unit_macros.svh"

module ext4_inode_locator_unit
  import e4il_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // configuration
  logic [2:0]  bsl_q;
  logic [16:0] ipg_q;
  logic [12:0] isz_q;
  logic [16:0] bpg_q;
  logic [2:0]  lay_q;
  logic [31:0] bga_q;
  logic [31:0] bgb_q;
  logic [10:0] dsz_q;

  seq_state_e  state_q, state_d;
  logic        issued_q, issued_d;
  logic        in_acc, out_load;

  logic [31:0] ino_m1_q;
  logic [47:0] table_q;
  logic        bad_q;
  logic [17:0] per_tbl_q, per_blk_q;
  logic [31:0] group_q, gblk_q, gsel_q;
  logic [16:0] part_q, blk_q, prem_q;
  logic [17:0] gidx_q;
  logic [62:0] acc_q, mcand_q;
  logic [31:0] mplier_q;
  logic [5:0]  mcnt_q;

  logic        out_valid_q;
  out_item_t   out_q;

  logic        div_start, div_done;
  logic [31:0] div_dvd, div_quo;
  logic [17:0] div_dvs, div_rem;
  logic        pwr_start, pwr_done, pwr_hit;
  logic        mul_start, mul_done;
  logic        step_done;

  logic [17:0] bs;
  logic [4:0]  bshift;
  logic        holds_bk;
  logic [62:0] tbase, gblk_bytes, base, desc_addr, ino_addr;
  logic [17:0] quo_fix;

  assign bs     = 18'd1024 << bsl_q;
  assign bshift = 5'(MinBlockLog) + 5'(bsl_q);
  assign quo_fix = (div_quo == 32'd0) ? 18'd1 : div_quo[17:0];

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign mul_done = (state_q == ST_MUL) && issued_q && (mcnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsl_q <= 3'd2;
      ipg_q <= 17'd8192;
      isz_q <= 13'd256;
      bpg_q <= 17'd32768;
      lay_q <= 3'd1;
      bga_q <= '0;
      bgb_q <= '0;
      dsz_q <= 11'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBlockSizeLog: bsl_q <= cfg_data_i[2:0];
        RegInodesPerGrp: ipg_q <= cfg_data_i[16:0];
        RegInodeSize:    isz_q <= cfg_data_i[12:0];
        RegBlocksPerGrp: bpg_q <= cfg_data_i[16:0];
        RegLayoutFlags:  lay_q <= cfg_data_i[2:0];
        RegBackupGroupA: bga_q <= cfg_data_i;
        RegBackupGroupB: bgb_q <= cfg_data_i;
        RegDescSize:     dsz_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  e4il_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  e4il_pwr_chk u_pwr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pwr_start),
    .group_i (gsel_q),
    .done_o  (pwr_done),
    .hit_o   (pwr_hit)
  );

  always_comb begin
    case (state_q)
      ST_TBL, ST_BLK, ST_GRP, ST_GIX, ST_PRT: step_done = div_done && issued_q;
      ST_BKP:  step_done = pwr_done && issued_q;
      ST_MUL:  step_done = mul_done;
      default: step_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = (in_data_i.inode_number == 32'd0) ? ST_FIN : ST_TBL;
      ST_TBL:  if (step_done) state_d = ST_BLK;
      ST_BLK:  if (step_done) state_d = ST_GRP;
      ST_GRP:  if (step_done) state_d = ST_GIX;
      ST_GIX:  if (step_done) state_d = ST_PRT;
      ST_PRT:  if (step_done) state_d = ST_BKP;
      ST_BKP:  if (step_done) state_d = ST_MUL;
      ST_MUL:  if (step_done) state_d = ST_FIN;
      ST_FIN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    div_start  = 1'b0;
    pwr_start  = 1'b0;
    mul_start  = 1'b0;
    div_dvd    = ino_m1_q;
    div_dvs    = {1'b0, ipg_q};
    issued_d   = issued_q;
    case (state_q)
      ST_TBL: begin
        div_dvd = 32'(bs);
        div_dvs = (dsz_q == 11'd0) ? bs : 18'(dsz_q);
      end
      ST_BLK: begin
        div_dvd = 32'(bs);
        div_dvs = (isz_q == 13'd0) ? bs : 18'(isz_q);
      end
      ST_GRP: begin
        div_dvd = ino_m1_q;
        div_dvs = (ipg_q == 17'd0) ? 18'd1 : {1'b0, ipg_q};
      end
      ST_GIX: begin
        div_dvd = group_q;
        div_dvs = per_tbl_q;
      end
      ST_PRT: begin
        div_dvd = 32'(part_q);
        div_dvs = per_blk_q;
      end
      default: ;
    endcase
    if (!issued_q) begin
      case (state_q)
        ST_TBL, ST_BLK, ST_GRP, ST_GIX, ST_PRT: begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end
        ST_BKP: begin
          pwr_start = 1'b1;
          issued_d  = 1'b1;
        end
        ST_MUL: begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end
        default: ;
      endcase
    end else if (step_done) begin
      issued_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ino_m1_q <= in_data_i.inode_number - 32'd1;
      table_q  <= in_data_i.table_start_block;
      bad_q    <= (in_data_i.inode_number == 32'd0);
    end
    if (step_done) begin
      case (state_q)
        ST_TBL: per_tbl_q <= quo_fix;
        ST_BLK: per_blk_q <= quo_fix;
        ST_GRP: begin
          group_q <= div_quo;
          part_q  <= div_rem[16:0];
        end
        ST_GIX: begin
          gblk_q <= div_quo;
          gidx_q <= div_rem;
        end
        ST_PRT: begin
          blk_q  <= div_quo[16:0];
          prem_q <= div_rem[16:0];
          gsel_q <= lay_q[2] ? (group_q - 32'(gidx_q)) : 32'd0;
        end
        default: ;
      endcase
    end
    if (mul_start) begin
      acc_q    <= '0;
      mcand_q  <= 63'({bpg_q, 7'd0} >> (3'd7 - bsl_q)) << MinBlockLog;
      mplier_q <= gsel_q;
      mcnt_q   <= 6'd32;
    end else if ((state_q == ST_MUL) && (mcnt_q != 6'd0)) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      mcnt_q   <= mcnt_q - 6'd1;
    end
    if (out_load) out_q <= bad_q ? out_item_t'({126'd0, 32'd0, 1'b1}) :
                                   out_item_t'({desc_addr, ino_addr, group_q, 1'b0});
  end

  // backup rule and address sums
  always_comb begin
    if (gsel_q == 32'd0) begin
      holds_bk = 1'b1;
    end else begin
      case (lay_q[1:0])
        SparseV1: holds_bk = pwr_hit;
        SparseV2: holds_bk = (gsel_q == bga_q) || (gsel_q == bgb_q);
        default:  holds_bk = 1'b1;
      endcase
    end
  end

  // offsets within a block stay below the block size
  assign tbase = acc_q + (holds_bk ? 63'(bs) : 63'd0)
               + (((gsel_q == 32'd0) && (bsl_q == 3'd0)) ? 63'(MinBlockBytes) : 63'd0);
  assign gblk_bytes = 63'(gblk_q) << bshift;
  assign base      = tbase + (lay_q[2] ? 63'd0 : gblk_bytes);
  assign desc_addr = base + 63'(gidx_q * 18'(dsz_q));
  assign ino_addr  = ((63'(table_q) + 63'(blk_q)) << bshift) + 63'(17'(isz_q) * prem_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `E4IL_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni,
                    in_valid_i && !in_stall_o, state_q != ST_IDLE)
  `E4IL_ASSERT_NEXT(a_load_gives_valid, clk_i, rst_ni, out_load, out_valid_o)
  `E4IL_ASSERT_SAME(a_bad_zero, clk_i, rst_ni, out_valid_o && out_data_o.bad_inode,
                    out_data_o.inode_address == 63'd0 && out_data_o.group_number == 32'd0)
  `E4IL_ASSERT_SAME(a_one_unit, clk_i, rst_ni, 1'b1, !(div_start && pwr_start))

endmodule
